// File: sv/rffa_pkg.sv
// shared constants and types for the radial force field accumulator
package rffa_pkg;

  localparam int unsigned ROOT_W = 32;
  localparam int unsigned RADICAND_W = 64;
  localparam int unsigned DVD_W = 48;
  localparam int unsigned DVS_W = 32;
  localparam int unsigned QUOT_W = 18;

  // 0.0001 in q32.32, squared distance must lie strictly above it
  localparam logic [63:0] MIN_D2 = 64'd429496;

  typedef enum logic [1:0] {
    KIND_INWARD        = 2'd0,
    KIND_OUTWARD       = 2'd1,
    KIND_CLOCKWISE     = 2'd2,
    KIND_ANTICLOCKWISE = 2'd3
  } kind_t;

endpackage

// File: sv/radial_force_field_accumulator.sv
// top level: sequencer, shared multiplier and force sums of the accumulator
// in_* carries one body and field pair per item; out_* carries the running
// force sum after that pair and a flag for a nonzero contribution.
// Each item gives exactly one result item, in order.
// A static pair or one too far apart in an axis goes from accept straight to
// the finish state, which loads the output register; one that fails the
// distance window check first goes through the squared distance, radius squared
// and the window check; a pair in range then also goes through the shared square
// root (start, load, 32 root bits), three passes through the shared divider (two
// direction components and the falloff ratio), and 10 steps of the shared 32x32
// multiplier and the saturating sums.
// in_tready is high only while the sequencer idles, so one pair is in work
// at a time; a new pair may be taken while the last result still waits.
// out_* is a holding register: a stalled receiver keeps the result steady
// and, once the next pair is done, holds the sequencer until it is taken.
// Reset (synchronous, rst_n low) clears the sums, the sequencer and out_tvalid.
// Sums are Q16.16, saturated to the signed 32-bit range; first_of_body
// clears them before its pair is added.
module radial_force_field_accumulator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // body_x, body_y, body_mass, field_x, field_y, field_radius, field_strength
  input  logic [223:0] in_tdata,
  // first_of_body, body_static, field_kind
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // force_x, force_y
  output logic [63:0]  out_tdata,
  // in_range
  output logic [0:0]   out_tuser
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_R2, S_CMP, S_SQRT, S_DIVX, S_DIVY, S_DIVR,
    S_SM, S_MM0, S_MM1, S_MM2, S_NX0, S_NX1, S_NX2, S_NY1, S_NY2, S_ACC, S_FIN
  } state_t;

  state_t state_r;

  // input field views
  logic signed [31:0] body_x, body_y, field_x, field_y, field_strength;
  logic [30:0]        body_mass, field_radius;
  logic               first_of_body, body_static;
  logic [1:0]         field_kind;

  assign body_x         = in_tdata[31:0];
  assign body_y         = in_tdata[63:32];
  assign body_mass      = in_tdata[94:64];
  assign field_x        = in_tdata[126:95];
  assign field_y        = in_tdata[158:127];
  assign field_radius   = in_tdata[189:159];
  assign field_strength = in_tdata[221:190];
  assign first_of_body  = in_tuser[0];
  assign body_static    = in_tuser[1];
  assign field_kind     = in_tuser[3:2];

  // differences toward the field centre
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  assign dx  = 33'(field_x) - 33'(body_x);
  assign dy  = 33'(field_y) - 33'(body_y);
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);

  // pair registers
  logic [30:0] ax_r, ay_r, rad_r, mass_r;
  logic [31:0] as_r;
  logic        sgnx_r, sgny_r, sgns_r;
  rffa_pkg::kind_t kind_r;

  logic [63:0] d2_r;
  logic [63:0] p_r;
  logic [63:0] acc_r;
  logic [31:0] dist_r;
  logic [17:0] nxm_r, nym_r;
  logic [16:0] fall_r;
  logic [13:0] sm_hi_r;
  logic [45:0] mm_r;
  logic [46:0] px_r, py_r;
  logic signed [31:0] sum_x_r, sum_y_r;
  logic        hit_r;
  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;
  logic        out_range_r;

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQX:   begin mul_a = {1'b0, ax_r};  mul_b = {1'b0, ax_r}; end
      S_SQY:   begin mul_a = {1'b0, ay_r};  mul_b = {1'b0, ay_r}; end
      S_R2:    begin mul_a = {1'b0, rad_r}; mul_b = {1'b0, rad_r}; end
      S_SM:    begin mul_a = as_r;          mul_b = {1'b0, mass_r}; end
      S_MM0:   begin mul_a = p_r[47:16];    mul_b = 32'(fall_r); end
      S_MM1:   begin mul_a = 32'(sm_hi_r);  mul_b = 32'(fall_r); end
      S_NX0:   begin mul_a = mm_r[31:0];    mul_b = 32'(nxm_r); end
      S_NX1:   begin mul_a = 32'(mm_r[45:32]); mul_b = 32'(nxm_r); end
      S_NX2:   begin mul_a = mm_r[31:0];    mul_b = 32'(nym_r); end
      S_NY1:   begin mul_a = 32'(mm_r[45:32]); mul_b = 32'(nym_r); end
      default: begin mul_a = '0;            mul_b = '0; end
    endcase
  end

  // partial products recombined: low product plus high product shifted up
  logic [63:0] comb_sum;
  assign comb_sum = acc_r + {p_r[31:0], 32'd0};

  // square root and divider
  logic        sqrt_start_r, sqrt_done;
  logic [31:0] sqrt_root;
  logic        div_start_r, div_done;
  logic [47:0] div_dvd_r;
  logic [31:0] div_dvs_r;
  logic [17:0] div_q;

  rffa_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start_r),
    .radicand (d2_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  rffa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd_r),
    .divisor  (div_dvs_r),
    .done     (div_done),
    .quot     (div_q)
  );

  // contributions and saturating sums
  logic               sx, sy;
  logic signed [49:0] qx, qy, cx, cy, tx, ty;
  assign sx = sgnx_r ^ sgns_r;
  assign sy = sgny_r ^ sgns_r;
  assign qx = sx ? -$signed(50'(px_r)) : $signed(50'(px_r));
  assign qy = sy ? -$signed(50'(py_r)) : $signed(50'(py_r));

  always_comb begin
    case (kind_r)
      rffa_pkg::KIND_INWARD:    begin cx = qx;  cy = qy;  end
      rffa_pkg::KIND_OUTWARD:   begin cx = -qx; cy = -qy; end
      rffa_pkg::KIND_CLOCKWISE: begin cx = -qy; cy = qx;  end
      default:                  begin cx = qy;  cy = -qx; end
    endcase
  end

  assign tx = 50'(sum_x_r) + cx;
  assign ty = 50'(sum_y_r) + cy;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7fffffff;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      hit_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      sqrt_start_r <= 1'b0;
      div_start_r  <= 1'b0;
    end else begin
      sqrt_start_r <= 1'b0;
      div_start_r  <= 1'b0;
      p_r          <= mul_a * mul_b;
      // the finish state owns out_tvalid_r while it waits
      if (out_tvalid_r && out_tready && state_r != S_FIN) out_tvalid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            ax_r   <= adx[30:0];
            ay_r   <= ady[30:0];
            sgnx_r <= dx[32];
            sgny_r <= dy[32];
            rad_r  <= field_radius;
            mass_r <= body_mass;
            sgns_r <= field_strength[31];
            as_r   <= field_strength[31] ? 32'(-field_strength) : 32'(field_strength);
            kind_r <= rffa_pkg::kind_t'(field_kind);
            hit_r  <= 1'b0;
            if (first_of_body) begin
              sum_x_r <= '0;
              sum_y_r <= '0;
            end
            // too far apart in either axis can never be in range
            if (body_static || adx[32:31] != 2'b00 || ady[32:31] != 2'b00) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_SQX;
            end
          end
        end
        S_SQX: state_r <= S_SQY;
        S_SQY: begin
          d2_r    <= p_r;
          state_r <= S_R2;
        end
        S_R2: begin
          d2_r    <= d2_r + p_r;
          state_r <= S_CMP;
        end
        S_CMP: begin
          // p_r holds radius squared here
          if (d2_r > rffa_pkg::MIN_D2 && d2_r < p_r) begin
            sqrt_start_r <= 1'b1;
            state_r      <= S_SQRT;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            dist_r      <= sqrt_root;
            div_dvd_r   <= {1'b0, ax_r, 16'd0};
            div_dvs_r   <= sqrt_root;
            div_start_r <= 1'b1;
            state_r     <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            nxm_r       <= div_q;
            div_dvd_r   <= {1'b0, ay_r, 16'd0};
            div_start_r <= 1'b1;
            state_r     <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            nym_r       <= div_q;
            div_dvd_r   <= {dist_r, 16'd0};
            div_dvs_r   <= {1'b0, rad_r};
            div_start_r <= 1'b1;
            state_r     <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_done) begin
            fall_r  <= 17'h10000 - {1'b0, div_q[15:0]};
            state_r <= S_SM;
          end
        end
        S_SM: state_r <= S_MM0;
        S_MM0: begin
          sm_hi_r <= p_r[61:48];
          state_r <= S_MM1;
        end
        S_MM1: begin
          acc_r   <= p_r;
          state_r <= S_MM2;
        end
        S_MM2: begin
          mm_r    <= comb_sum[61:16];
          state_r <= S_NX0;
        end
        S_NX0: state_r <= S_NX1;
        S_NX1: begin
          acc_r   <= p_r;
          state_r <= S_NX2;
        end
        S_NX2: begin
          px_r    <= comb_sum[62:16];
          state_r <= S_NY1;
        end
        S_NY1: begin
          acc_r   <= p_r;
          state_r <= S_NY2;
        end
        S_NY2: begin
          py_r    <= comb_sum[62:16];
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_x_r <= sat32(tx);
          sum_y_r <= sat32(ty);
          hit_r   <= (px_r != '0) || (py_r != '0);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {sum_y_r, sum_x_r};
            out_range_r  <= hit_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_range_r;

endmodule

// File: sv/rffa_isqrt.sv
// iterative integer square root, one root bit per cycle
module rffa_isqrt (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [rffa_pkg::RADICAND_W-1:0]     radicand,
  output logic                                done,
  output logic [rffa_pkg::ROOT_W-1:0]         root
);

  localparam int unsigned RW = rffa_pkg::ROOT_W;

  logic [rffa_pkg::RADICAND_W-1:0] v_r;
  logic [RW+1:0]                   rem_r;
  logic [RW-1:0]                   root_r;
  logic [4:0]                      cnt_r;
  logic                            busy_r;
  logic                            done_r;

  logic [RW+3:0] rem_t;
  logic [RW+3:0] trial;
  logic [RW+3:0] rem_d;
  logic          ge;

  assign rem_t = {rem_r, v_r[rffa_pkg::RADICAND_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign rem_d = rem_t - trial;
  assign ge    = (rem_t >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        v_r    <= {v_r[rffa_pkg::RADICAND_W-3:0], 2'b00};
        rem_r  <= ge ? rem_d[RW+1:0] : rem_t[RW+1:0];
        root_r <= {root_r[RW-2:0], ge};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: sv/rffa_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit its width
module rffa_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rffa_pkg::DVD_W-1:0]     dividend,
  input  logic [rffa_pkg::DVS_W-1:0]     divisor,
  output logic                           done,
  output logic [rffa_pkg::QUOT_W-1:0]    quot
);

  localparam int unsigned QW = rffa_pkg::QUOT_W;
  localparam int unsigned SW = rffa_pkg::DVS_W;
  localparam int unsigned HW = rffa_pkg::DVD_W - QW;

  logic [SW-1:0] rem_r;
  logic [SW-1:0] dvs_r;
  logic [QW-1:0] dvd_r;
  logic [QW-1:0] q_r;
  logic [4:0]    cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [SW:0] t;
  logic [SW:0] diff;
  logic        ge;

  assign t    = {rem_r, dvd_r[QW-1]};
  assign diff = t - {1'b0, dvs_r};
  assign ge   = (t >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // high part is below the divisor, so only the low bits make quotient
        rem_r  <= SW'(dividend[rffa_pkg::DVD_W-1 -: HW]);
        dvd_r  <= dividend[QW-1:0];
        dvs_r  <= divisor;
        q_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[SW-1:0] : t[SW-1:0];
        q_r   <= {q_r[QW-2:0], ge};
        dvd_r <= {dvd_r[QW-2:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: verif/radial_force_field_accumulator_tb.sv
// testbench for the radial force field accumulator: random and directed pairs, scoreboard
`timescale 1ns / 1ps
module radial_force_field_accumulator_tb;

  // body and field data as packed on in_tdata, lowest field last in the list
  typedef struct packed {
    logic [1:0]         pad;
    logic signed [31:0] strength;
    logic [30:0]        radius;
    logic signed [31:0] fy;
    logic signed [31:0] fx;
    logic [30:0]        mass;
    logic signed [31:0] by;
    logic signed [31:0] bx;
  } pair_data_t;

  // flags as packed on in_tuser
  typedef struct packed {
    rffa_pkg::kind_t kind;
    logic            is_static;
    logic            first;
  } pair_flags_t;

  typedef struct {
    pair_data_t  d;
    pair_flags_t f;
  } pair_t;

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               hit;
  } force_t;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [223:0] in_tdata;
  logic [3:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic [0:0]   out_tuser;

  pair_t   pending_pairs[$];
  force_t  expected_forces[$];
  longint  sum_fx, sum_fy;
  int      error_count;
  int      sender_idle_pct, receiver_stall_pct;
  int      quiet_cycles;
  logic    in_took;

  radial_force_field_accumulator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // floor of the square root, digit by digit
  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // q16.16 product truncated toward zero
  function automatic longint q_product(longint a, longint b);
    bit [63:0] ua;
    bit [63:0] ub;
    longint    p;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = longint'((ua * ub) >> 16);
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint saturate32(longint t);
    if (t > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (t < -64'sh8000_0000) return -64'sh8000_0000;
    return t;
  endfunction

  // running force sum after one pair
  function automatic force_t predict_force(pair_t p);
    longint    dx, dy, nx, ny, m, cx, cy;
    bit [63:0] ax, ay, d2, r2, root_d, nxm, nym, ratio, fall, mag_s, sm, mm, rad, mass;
    force_t    r;
    r.hit = 1'b0;
    if (p.f.first) begin
      sum_fx = 0;
      sum_fy = 0;
    end
    if (!p.f.is_static) begin
      dx = longint'(p.d.fx) - longint'(p.d.bx);
      dy = longint'(p.d.fy) - longint'(p.d.by);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      rad = {33'd0, p.d.radius};
      mass = {33'd0, p.d.mass};
      if (ax < 64'h8000_0000 && ay < 64'h8000_0000) begin
        d2 = ax * ax + ay * ay;
        r2 = rad * rad;
        if (d2 > rffa_pkg::MIN_D2 && d2 < r2) begin
          root_d = int_sqrt(d2);
          nxm = (ax << 16) / root_d;
          nym = (ay << 16) / root_d;
          nx = dx < 0 ? -longint'(nxm) : longint'(nxm);
          ny = dy < 0 ? -longint'(nym) : longint'(nym);
          ratio = (root_d << 16) / rad;
          fall = 64'd65536 - ratio;
          mag_s = p.d.strength < 0 ? -longint'(p.d.strength) : longint'(p.d.strength);
          sm = (mag_s * mass) >> 16;
          mm = (sm * fall) >> 16;
          m = p.d.strength < 0 ? -longint'(mm) : longint'(mm);
          case (p.f.kind)
            rffa_pkg::KIND_INWARD: begin
              cx = q_product(nx, m);
              cy = q_product(ny, m);
            end
            rffa_pkg::KIND_OUTWARD: begin
              cx = -q_product(nx, m);
              cy = -q_product(ny, m);
            end
            rffa_pkg::KIND_CLOCKWISE: begin
              cx = -q_product(ny, m);
              cy = q_product(nx, m);
            end
            default: begin
              cx = q_product(ny, m);
              cy = -q_product(nx, m);
            end
          endcase
          sum_fx = saturate32(sum_fx + cx);
          sum_fy = saturate32(sum_fy + cy);
          r.hit = (cx != 0 || cy != 0);
        end
      end
    end
    r.fx = sum_fx[31:0];
    r.fy = sum_fy[31:0];
    return r;
  endfunction

  function automatic pair_t make_pair(bit first, bit is_static, rffa_pkg::kind_t kind,
                                      int bx, int by, int mass, int fx, int fy,
                                      int radius, int strength);
    pair_t p;
    p.d = '{pad: 2'b00, strength: strength, radius: radius[30:0], fy: fy, fx: fx,
            mass: mass[30:0], by: by, bx: bx};
    p.f = '{kind: kind, is_static: is_static, first: first};
    return p;
  endfunction

  // append one pair to the driver's queue
  function automatic void queue_pair(pair_t p);
    pending_pairs = {pending_pairs, p};
  endfunction

  // mostly pairs near their field so that the force path is exercised
  function automatic pair_t random_pair();
    pair_t p;
    int    k, dx, dy;
    p.d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p.d.pad = 2'b00;
    p.f = 4'($urandom_range(15));
    p.f.first = ($urandom_range(5) == 0);
    if ($urandom_range(9) < 8) begin
      k = $urandom_range(20);
      dx = $signed($urandom_range(0, 2 << k)) - (1 << k);
      dy = $signed($urandom_range(0, 2 << k)) - (1 << k);
      p.d.bx = p.d.fx - dx;
      p.d.by = p.d.fy - dy;
      p.d.radius = 31'($urandom_range(0, 4 << k));
      p.d.strength = $signed($urandom) >>> $urandom_range(0, 31);
      p.d.mass = 31'($urandom >> $urandom_range(1, 31));
      p.f.is_static = ($urandom_range(9) == 0);
    end
    return p;
  endfunction

  // driver: one item at a time, new data only after the previous one was taken
  always @(negedge clk) begin
    pair_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      if (!in_tvalid || in_took) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          p = pending_pairs.pop_front();
          in_tdata <= p.d;
          in_tuser <= p.f;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on accepted pairs, check accepted results
  always @(posedge clk) begin
    pair_t  p;
    force_t want;
    force_t got;
    in_took <= in_tvalid && in_tready;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no item moved for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
      if (in_tvalid && in_tready) begin
        p.d = pair_data_t'(in_tdata);
        p.f = pair_flags_t'(in_tuser);
        expected_forces = {expected_forces, predict_force(p)};
      end
      if (out_tvalid && out_tready) begin
        got.fx = out_tdata[31:0];
        got.fy = out_tdata[63:32];
        got.hit = out_tuser[0];
        if (expected_forces.size() == 0) begin
          $display("%0t: unexpected result fx=%0d fy=%0d in_range=%0d",
                   $time, got.fx, got.fy, got.hit);
          error_count++;
        end else begin
          want = expected_forces.pop_front();
          if (got.fx !== want.fx) begin
            $display("%0t: force_x expected %0d actual %0d", $time, want.fx, got.fx);
            error_count++;
          end
          if (got.fy !== want.fy) begin
            $display("%0t: force_y expected %0d actual %0d", $time, want.fy, got.fy);
            error_count++;
          end
          if (got.hit !== want.hit) begin
            $display("%0t: in_range expected %0d actual %0d", $time, want.hit, got.hit);
            error_count++;
          end
        end
      end
    end
  end

  // hold the sender until every queued item is accepted and answered
  task automatic drain_all();
    while (pending_pairs.size() != 0 || in_tvalid || expected_forces.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) queue_pair(random_pair());
    drain_all();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    in_took = 1'b0;
    quiet_cycles = 0;
    error_count = 0;
    sum_fx = 0;
    sum_fy = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: each kind, just inside and outside the near limit, zero radius,
    // huge separation, static body, restart, zero magnitude and saturation
    queue_pair(make_pair(1, 0, rffa_pkg::KIND_INWARD, 0, 0, 65536, 65536, 0, 131072, 65536));
    queue_pair(make_pair(0, 0, rffa_pkg::KIND_OUTWARD, 0, 0, 65536, 0, 65536, 131072, 65536));
    queue_pair(make_pair(0, 0, rffa_pkg::KIND_CLOCKWISE, 0, 0, 65536, 40000, 30000,
                         131072, -65536));
    queue_pair(make_pair(0, 0, rffa_pkg::KIND_ANTICLOCKWISE, 0, 0, 65536, -40000, 30000,
                         131072, 65536));
    queue_pair(make_pair(0, 0, rffa_pkg::KIND_INWARD, 0, 0, 65536, 655, 0, 131072, 65536));
    queue_pair(make_pair(0, 0, rffa_pkg::KIND_INWARD, 0, 0, 65536, 656, 0, 131072, 65536));
    queue_pair(make_pair(0, 0, rffa_pkg::KIND_INWARD, 0, 0, 65536, 65536, 0, 65536, 65536));
    queue_pair(make_pair(0, 0, rffa_pkg::KIND_INWARD, 0, 0, 65536, 100, 100, 0, 65536));
    queue_pair(make_pair(0, 0, rffa_pkg::KIND_INWARD, 32'h8000_0000, 0, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    queue_pair(make_pair(0, 1, rffa_pkg::KIND_INWARD, 0, 0, 65536, 65536, 0, 131072, 65536));
    queue_pair(make_pair(1, 1, rffa_pkg::KIND_OUTWARD, 0, 0, 65536, 65536, 0, 131072, 65536));
    queue_pair(make_pair(0, 0, rffa_pkg::KIND_INWARD, 0, 0, 65536, 65536, 0, 131072, 0));
    queue_pair(make_pair(0, 0, rffa_pkg::KIND_INWARD, 0, 0, 0, 65536, 0, 131072, 65536));
    repeat (4) queue_pair(make_pair(0, 0, rffa_pkg::KIND_INWARD, 0, 0, 32'h7FFF_FFFF,
                                    1000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    repeat (4) queue_pair(make_pair(0, 0, rffa_pkg::KIND_CLOCKWISE, 0, 0, 32'h7FFF_FFFF,
                                    1000, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    queue_pair(make_pair(1, 0, rffa_pkg::KIND_ANTICLOCKWISE, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h7FFF_0000, 32'h8000_1000,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF));
    drain_all();

    run_random(500, 0, 0);
    run_random(300, 80, 0);
    run_random(300, 0, 80);
    run_random(330, 9, 9);

    repeat (150) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
